>>> rtl/core/pdist_pkg.sv
// Shared constants and types for the projected distance pipeline.
package pdist_pkg;

  localparam int OUT_BITS    = 26;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [OUT_BITS-1:0] dist_t;

endpackage

>>> rtl/core/projected_distance_3d.sv
// Top level: pipelined point-to-line projection distance in 3D fixed point.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_tvalid / s_tready         s_tdata: 9 signed coordinates
//  m_axis    out  m_tvalid / m_tready         m_tdata: distance, m_tuser: degenerate
//
// One transaction per cycle is accepted while m_axis does not stall.
// Five stages form the differences, products, dot sums and the square of the
// numerator; then one stage per result bit runs a restoring root-and-divide
// recurrence (shift-and-add only).
// Reset (rst, synchronous) clears only the valid bits; payload is not reset.
// A full stage holds while the stage after it is full and stalled, so a stall on
// m_axis backs up stage by stage and nothing is dropped or repeated.
module projected_distance_3d
  import pdist_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata from bit 0 up: line_start_x, line_start_y, line_start_z,
  // line_end_x, line_end_y, line_end_z, point_x, point_y, point_z, zero fill
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata from bit 0 up: projected_distance, zero fill
  output logic [OUT_TDATA_W-1:0]                 m_tdata,
  // m_tuser: degenerate
  output logic                                   m_tuser
);

  localparam int C   = COORD_BITS;
  localparam int PW  = 2*C + 2;            // product of two (C+1)-bit values
  localparam int SW  = 2*C + 3;            // signed dot sum
  localparam int NW  = 2*C + 2;            // numerator magnitude
  localparam int DW  = 2*C + 2;            // d.d
  localparam int HL  = (NW + 1) / 2;       // low half of numerator
  localparam int HH  = NW - HL;            // high half of numerator
  localparam int TW  = DW + OUT_BITS;      // running D*q
  localparam int RA  = 2*NW;
  localparam int RB  = DW + 2*OUT_BITS;
  localparam int RW  = ((RA > RB) ? RA : RB) + 1;
  localparam int NST = 5 + OUT_BITS;

  // Per-stage valid and ready chain.
  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = m_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: d = E - S, w = P - E.
  logic signed [C:0] dd [3];
  logic signed [C:0] ww [3];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        dd[i] <= $signed({s_tdata[(3+i)*C + C-1], s_tdata[(3+i)*C +: C]})
               - $signed({s_tdata[i*C + C-1], s_tdata[i*C +: C]});
        ww[i] <= $signed({s_tdata[(6+i)*C + C-1], s_tdata[(6+i)*C +: C]})
               - $signed({s_tdata[(3+i)*C + C-1], s_tdata[(3+i)*C +: C]});
      end
    end
  end

  // Stage 1: the six products.
  logic signed [PW-1:0] pwd [3];
  logic signed [PW-1:0] pdd [3];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        pwd[i] <= ww[i] * dd[i];
        pdd[i] <= dd[i] * dd[i];
      end
    end
  end

  // Stage 2: dot sums, numerator magnitude, degenerate flag.
  logic signed [SW-1:0] num_sum;
  logic [SW-1:0]        num_abs;
  logic [DW-1:0]        den_sum;
  logic [NW-1:0]        nabs;
  logic [DW-1:0]        den2;
  logic                 deg2;

  always_comb begin
    num_sum = SW'(pwd[0]) + SW'(pwd[1]) + SW'(pwd[2]);
    num_abs = num_sum[SW-1] ? SW'(-num_sum) : SW'(num_sum);
    den_sum = DW'(unsigned'(pdd[0])) + DW'(unsigned'(pdd[1]))
            + DW'(unsigned'(pdd[2]));
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      nabs <= num_abs[NW-1:0];
      den2 <= den_sum;
      deg2 <= (den_sum == '0);
    end
  end

  // Stage 3: partial products of the numerator square.
  logic [2*HH-1:0]   sq_hh;
  logic [HH+HL-1:0]  sq_hl;
  logic [2*HL-1:0]   sq_ll;
  logic [DW-1:0]     den3;
  logic              deg3;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sq_hh <= nabs[NW-1:HL] * nabs[NW-1:HL];
      sq_hl <= nabs[NW-1:HL] * nabs[HL-1:0];
      sq_ll <= nabs[HL-1:0] * nabs[HL-1:0];
      den3  <= den2;
      deg3  <= deg2;
    end
  end

  // Recurrence registers; index 0 is written by stage 4.
  logic [RW-1:0]       rem_p [OUT_BITS+1];
  logic [TW-1:0]       tq_p  [OUT_BITS+1];
  logic [OUT_BITS-1:0] q_p   [OUT_BITS+1];
  logic [DW-1:0]       den_p [OUT_BITS+1];
  logic                deg_p [OUT_BITS+1];

  // Stage 4: assemble N*N.
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rem_p[0] <= (RW'(sq_hh) << (2*HL)) + (RW'(sq_hl) << (HL+1)) + RW'(sq_ll);
      tq_p[0]  <= '0;
      q_p[0]   <= '0;
      den_p[0] <= den3;
      deg_p[0] <= deg3;
    end
  end

  // Root stages: try bit b; (q+2^b)^2*D - q^2*D = 2^(b+1)*D*q + 2^(2b)*D.
  for (genvar j = 0; j < OUT_BITS; j++) begin : g_root
    localparam int B = OUT_BITS - 1 - j;
    logic [RW-1:0] sub;
    logic          take;

    always_comb begin
      sub  = (RW'(tq_p[j]) << (B+1)) + (RW'(den_p[j]) << (2*B));
      take = (sub <= rem_p[j]);
    end

    always_ff @(posedge clk) begin
      if (rdy[5+j]) begin
        rem_p[j+1] <= take ? rem_p[j] - sub : rem_p[j];
        tq_p[j+1]  <= take ? tq_p[j] + (TW'(den_p[j]) << B) : tq_p[j];
        q_p[j+1]   <= take ? (q_p[j] | (OUT_BITS'(1) << B)) : q_p[j];
        den_p[j+1] <= den_p[j];
        deg_p[j+1] <= deg_p[j];
      end
    end
  end

  dist_t dist_out;
  assign dist_out = deg_p[OUT_BITS] ? '0 : q_p[OUT_BITS];

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = OUT_TDATA_W'(dist_out);
  assign m_tuser  = deg_p[OUT_BITS];

  // An empty output stage leaves the whole chain ready.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NST-1] |-> s_tready)
    else $error("input not ready with empty output stage");

  // A stalled stage-4 item holds its remainder.
  a_hold_rem: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !rdy[5] |=> $stable(rem_p[0]))
    else $error("stage 4 remainder changed under stall");

  // The flag follows the carried denominator.
  a_deg_den: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (den_p[OUT_BITS] != '0) |-> !m_tuser)
    else $error("degenerate flag with nonzero denominator");

endmodule

>>> tb/sv/projected_distance_3d_tb.sv
// Testbench for projected_distance_3d: streamed queries checked against an exact predictor.
`timescale 1ns / 1ps

module projected_distance_3d_tb;
  import pdist_pkg::*;

  localparam int CB      = 24;
  localparam int IN_W    = ((9 * CB + 7) / 8) * 8;
  localparam int LATENCY = OUT_BITS + 5;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    dist_t distance;
    logic  degen;
  } dist_result_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  logic [IN_W-1:0] pending_queries[$];
  dist_result_t    expected_dists[$];
  int              tx_idle_pct = 0;
  int              rx_idle_pct = 0;
  int              n_raised = 0;
  int              n_accepted = 0;
  int              n_results = 0;
  int              n_degen = 0;
  int              n_errors = 0;

  projected_distance_3d #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact distance: largest q below 2^OUT_BITS with q*q*|d|^2 <= (w.d)^2.
  function automatic dist_result_t project_distance(input logic [IN_W-1:0] w);
    coord_t              c[9];
    logic signed [63:0]  dv, wv, num;
    logic [63:0]         den, mag;
    logic [127:0]        nsq, trial;
    dist_t               q, cand;
    dist_result_t        r;
    int                  i;
    for (i = 0; i < 9; i++) c[i] = w[i*CB +: CB];
    num = 0;
    den = 0;
    for (i = 0; i < 3; i++) begin
      dv  = 64'(c[3+i]) - 64'(c[i]);
      wv  = 64'(c[6+i]) - 64'(c[3+i]);
      num = num + wv * dv;
      den = den + 64'(dv * dv);
    end
    r.distance = '0;
    r.degen    = (den == 0);
    if (r.degen) return r;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    nsq = 128'(mag) * 128'(mag);
    q = '0;
    for (i = OUT_BITS - 1; i >= 0; i--) begin
      cand  = q | (dist_t'(1) << i);
      trial = 128'(cand) * 128'(cand) * 128'(den);
      if (trial <= nsq) q = cand;
    end
    r.distance = q;
    return r;
  endfunction

  task automatic add_query(input coord_t sx, sy, sz, ex, ey, ez, px, py, pz);
    pending_queries.push_back(IN_W'({pz, py, px, ez, ey, ex, sz, sy, sx}));
  endtask

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(8191)) - coord_t'(4096);
      default: begin
        case ($urandom_range(4))
          0: return {1'b1, {(CB-1){1'b0}}};
          1: return {1'b0, {(CB-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  // Mostly full-range queries, plus small, degenerate, near-end, extreme and on-line ones.
  task automatic add_random_query();
    coord_t s[3], e[3], p[3];
    int     kind, mode, i;
    kind = $urandom_range(9);
    mode = (kind <= 3) ? 0 : (kind <= 5) ? 1 : (kind == 8) ? 2 : 0;
    for (i = 0; i < 3; i++) begin
      s[i] = pick_coord(mode);
      e[i] = pick_coord(mode);
      p[i] = pick_coord(mode);
    end
    for (i = 0; i < 3; i++) begin
      if (kind == 6) e[i] = s[i];
      if (kind == 7) p[i] = e[i] + pick_coord(1);
      if (kind == 9) p[i] = s[i];
    end
    add_query(s[0], s[1], s[2], e[0], e[1], e[2], p[0], p[1], p[2]);
  endtask

  task automatic add_directed_queries();
    coord_t mn, mx;
    mn = {1'b1, {(CB-1){1'b0}}};
    mx = {1'b0, {(CB-1){1'b1}}};
    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0);                  // all zero: coincident
    add_query(mx, mn, 5, mx, mn, 5, mn, mx, 0);            // coincident, far point
    add_query(mn, mn, mn, mx, mx, mx, mn, mn, mn);         // longest line, point at start
    add_query(mn, mn, mn, mx, mx, mx, mx, mx, mx);         // point at end: zero
    add_query(mx, mx, mx, mn, mn, mn, mx, mx, mx);         // reversed long line
    add_query(mn, mn, mn, mx, mx, mx, mn, mx, mn);
    add_query(mn, 0, 0, mx, 0, 0, mx, mn, mx);             // axis line, far off-axis point
    add_query(0, 0, 0, 1, 0, 0, mn, mx, mn);               // tiny line, huge projection
    add_query(0, 0, 0, 0, 0, 1, 0, 0, mx);
    add_query(0, 0, 0, 256, 256, 0, 0, 256, 0);            // rounding toward zero
    add_query(-1, -1, -1, 0, 0, 0, 1, 1, 1);
    add_query(100, 200, 300, 103, 204, 300, 106, 208, 300); // point beyond end, on line
    add_query(mx, mx, mx, mx, mx, mx - 1, mn, mn, mn);
  endtask

  // Driver: present the next query once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
      if (!s_tvalid || n_accepted == n_raised) begin
        if (pending_queries.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_queries.pop_front();
          n_raised <= n_raised + 1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict each accepted query, check each delivered distance.
  always @(posedge clk) begin
    dist_result_t exp_r;
    if (!rst && s_tvalid && s_tready) begin
      expected_dists.push_back(project_distance(s_tdata));
      n_accepted <= n_accepted + 1;
    end
    if (!rst && m_tvalid && m_tready) begin
      n_results <= n_results + 1;
      if (expected_dists.size() == 0) begin
        n_errors <= n_errors + 1;
        if (n_errors < 10) $display("ERROR: unexpected result dist=%0d degen=%0b",
                                    m_tdata[OUT_BITS-1:0], m_tuser);
      end else begin
        exp_r = expected_dists.pop_front();
        if (exp_r.degen) n_degen <= n_degen + 1;
        if (m_tdata !== OUT_TDATA_W'(exp_r.distance) || m_tuser !== exp_r.degen) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10)
            $display("ERROR: result %0d: dist exp %0d got %0d, degen exp %0b got %0b",
                     n_results, exp_r.distance, m_tdata, exp_r.degen, m_tuser);
        end
      end
    end
  end

  initial begin
    int phase, k, drain;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 66 : 0;
      rx_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 22 : 0;
      if (phase == 0) add_directed_queries();
      for (k = 0; k < 480; k++) add_random_query();
      // hold off new queries until the pipeline has fully drained
      while (pending_queries.size() > 0 || s_tvalid) @(posedge clk);
      while (expected_dists.size() > 0) @(posedge clk);
    end
    drain = 0;
    while (drain < 4 * LATENCY) begin
      @(posedge clk);
      drain++;
    end
    if (expected_dists.size() > 0) n_errors++;
    $display("Covered %0d queries (%0d coincident lines) over three handshake idle mixes;",
             n_accepted, n_degen);
    $display("checked %0d distances, %0d mismatches.", n_results, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", expected_dists.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> projected_distance_3d.f
rtl/core/pdist_pkg.sv
rtl/core/projected_distance_3d.sv
tb/sv/projected_distance_3d_tb.sv
